/* rtl/atilt_pkg.sv */
// Package for the accelerometer tilt block: payload types, constants, arctangent table.
package atilt_pkg;

   localparam int unsigned ThreshWidth    = 15;
   localparam int unsigned MaskWidth      = 8;
   localparam int unsigned SampleWidth    = 16;
   localparam int unsigned CordicSteps    = 21;
   localparam int unsigned StepIdxWidth   = 5;
   localparam int unsigned CordicWidth    = 40;
   localparam int unsigned AngleWidth     = 24;
   localparam int unsigned SumSqWidth     = 33;
   localparam int unsigned RootWidth      = 33;
   localparam int unsigned RadWidth       = 66;
   localparam int unsigned RootSteps      = 33;
   localparam int unsigned RootIdxWidth   = 6;
   localparam int unsigned TiltLimit      = 23040;
   localparam int unsigned CsrIndexWidth  = 1;
   localparam logic [ThreshWidth-1:0] ThreshReset = 15'd8000;
   localparam logic [MaskWidth-1:0]   MaskReset   = 8'h03;

   localparam logic [CsrIndexWidth-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MASK      = 1'd1;

   typedef struct packed {
      logic        [7:0]  status_byte;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] tilt_x;
      logic signed [15:0] tilt_y;
      logic signed [15:0] tilt_z;
      logic               motion_event;
   } rsp_type;

   // Per-axis cell control: load new operands, advance one step
   typedef struct packed {
      logic load;
      logic step;
      logic [StepIdxWidth-1:0] idx;
   } cell_ctl_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic [AngleWidth-1:0] atan_q16(input logic [StepIdxWidth-1:0] i);
      logic [AngleWidth-1:0] v;
      begin
         case (i)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            5'd20: v = 24'd4;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/atilt_cell.sv */
// One axis cell: square sum, bit-serial square root, then iterative CORDIC vectoring.
module atilt_cell (
   input  logic                                   clock,
   input  atilt_pkg::cell_ctl_type                ctl,
   input  logic                                   root_step,
   input  logic signed [atilt_pkg::SampleWidth-1:0] a_in,
   input  logic signed [atilt_pkg::SampleWidth-1:0] b_in,
   input  logic signed [atilt_pkg::SampleWidth-1:0] c_in,
   output logic signed [atilt_pkg::SampleWidth-1:0] tilt
);
   localparam int unsigned W  = atilt_pkg::CordicWidth;
   localparam int unsigned RW = atilt_pkg::RadWidth;
   localparam int unsigned QW = atilt_pkg::RootWidth;

   logic signed [W-1:0] x_ff, y_ff;
   logic signed [W-1:0] x_in, y_in;
   logic signed [atilt_pkg::AngleWidth+1:0] z_ff, z_in;
   logic [RW-1:0] rad_ff, rad_in;
   logic [QW+1:0] rem_ff, rem_in;
   logic [QW-1:0] root_ff, root_in;
   logic [1:0]    mode_ff, mode_in;
   logic signed [atilt_pkg::SampleWidth-1:0] a_ff;
   logic [QW+1:0] trial;
   logic signed [W-1:0] xs, ys;
   logic signed [atilt_pkg::AngleWidth+1:0] ang;
   logic signed [atilt_pkg::AngleWidth+1:0] zr;
   logic signed [atilt_pkg::AngleWidth-7:0] zq;
   logic signed [31:0] bb, cc;

   always_comb begin
      bb     = b_in * b_in;
      cc     = c_in * c_in;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      mode_in = mode_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      trial  = {root_ff, 2'b01};
      xs     = x_ff >>> ctl.idx;
      ys     = y_ff >>> ctl.idx;
      ang    = (atilt_pkg::AngleWidth+2)'(atilt_pkg::atan_q16(ctl.idx));
      // load: radicand is sumsq * 2^32, special cases kept in mode
      if (ctl.load) begin
         rad_in  = {1'b0, ({1'b0, bb[31:0]} + {1'b0, cc[31:0]}), 32'd0};
         rem_in  = '0;
         root_in = '0;
         z_in    = '0;
         y_in    = W'(a_in) <<< 16;
         mode_in = (b_in == 0 && c_in == 0) ? 2'd1 : ((a_in == 0) ? 2'd2 : 2'd0);
      end else if (root_step) begin
         // one root bit per cycle
         if ({rem_ff[QW-1:0], rad_ff[RW-1:RW-2]} >= trial) begin
            rem_in  = {rem_ff[QW-1:0], rad_ff[RW-1:RW-2]} - trial;
            root_in = {root_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[QW-1:0], rad_ff[RW-1:RW-2]};
            root_in = {root_ff[QW-2:0], 1'b0};
         end
         rad_in = {rad_ff[RW-3:0], 2'b00};
         x_in   = W'(root_in);
      end else if (ctl.step) begin
         // advance one CORDIC rotation
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      mode_ff <= mode_in;
      if (ctl.load) a_ff <= a_in;
   end

   // round, clamp, apply special cases
   always_comb begin
      zr = z_ff + 26'sd128;
      zq = zr[atilt_pkg::AngleWidth+1:8];
      if (mode_ff == 2'd1)
         tilt = (a_ff > 0) ? 16'sd23040 : ((a_ff < 0) ? -16'sd23040 : 16'sd0);
      else if (mode_ff == 2'd2)
         tilt = '0;
      else if (zq > 18'sd23040)
         tilt = 16'sd23040;
      else if (zq < -18'sd23040)
         tilt = -16'sd23040;
      else
         tilt = zq[15:0];
   end
endmodule

/* rtl/accel_tilt_angles_with_motion_flag.sv */
// Top level of the accelerometer tilt block with gyro motion flag.
// Usage:
//  - req_ carries a status byte plus accel and gyro triples. A request is
//    taken when req_valid is high and req_stall low. When any status bit
//    under ready_mask is set, the triples are latched; otherwise the last
//    latched triples (zero after reset) are used.
//  - rsp_ returns three Q8 tilt angles in degrees and the motion flag; a
//    response is taken when rsp_valid is high and rsp_stall low.
//  - csr_ writes motion_threshold (index 0) or ready_mask (index 1);
//    csr_ready is always high; write only while idle.
// Sequence: the accepting edge loads the axis cells, then the square-root
// steps (one root bit per cycle) and the CORDIC steps follow, then the
// angles move into the response register, which raises rsp_valid. The
// sequence is set by the bit-serial root and the iterative rotation in
// each of the three axis cells. One request is in flight at a time;
// req_stall stays high from the taken request until its result enters
// the response register.
// Reset (synchronous, high) clears the held samples and restores register
// defaults. While the receiver stalls the response is held, and a finished
// result waits (req_stall high) until the response register is free.
module accel_tilt_angles_with_motion_flag #(
   parameter int unsigned THRESH_RESET = atilt_pkg::ThreshReset
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  atilt_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output atilt_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [atilt_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ROOT = 4'b0010,
      ST_ROT  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [atilt_pkg::RootIdxWidth-1:0] cnt_ff, cnt_in;
   logic [atilt_pkg::ThreshWidth-1:0] thresh_ff;
   logic [atilt_pkg::MaskWidth-1:0]   mask_ff;
   logic signed [15:0] ha_ff [3];
   logic signed [15:0] hr_ff [3];
   logic signed [15:0] na [3];
   logic signed [15:0] tilt [3];
   logic rsp_valid_ff;
   atilt_pkg::rsp_type rsp_ff;
   atilt_pkg::cell_ctl_type ctl;
   logic root_step, take, fresh, motion;

   assign csr_ready = 1'b1;
   assign take      = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign fresh     = (req_data.status_byte & mask_ff) != '0;

   // select new or held samples
   always_comb begin
      if (fresh) begin
         na[0] = req_data.accel_x; na[1] = req_data.accel_y; na[2] = req_data.accel_z;
      end else begin
         na[0] = ha_ff[0]; na[1] = ha_ff[1]; na[2] = ha_ff[2];
      end
   end

   // sequence: load, root bits, rotations, hand off
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctl.load  = take;
      ctl.step  = 1'b0;
      ctl.idx   = cnt_ff[atilt_pkg::StepIdxWidth-1:0];
      root_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_ROOT;
               cnt_in   = '0;
            end
         end
         ST_ROOT: begin
            root_step = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == 6'(atilt_pkg::RootSteps - 1)) begin
               state_in = ST_ROT;
               cnt_in   = '0;
            end
         end
         ST_ROT: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 6'(atilt_pkg::CordicSteps - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      motion = 1'b0;
      for (int k = 0; k < 3; k++)
         if (hr_ff[k] > $signed({1'b0, thresh_ff})) motion = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         thresh_ff    <= atilt_pkg::ThreshWidth'(THRESH_RESET);
         mask_ff      <= atilt_pkg::MaskReset;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            ha_ff[k] <= '0;
            hr_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_index == atilt_pkg::CSR_THRESHOLD)
            thresh_ff <= csr_wdata[atilt_pkg::ThreshWidth-1:0];
         if (csr_valid && csr_index == atilt_pkg::CSR_MASK)
            mask_ff <= csr_wdata[atilt_pkg::MaskWidth-1:0];
         // latch fresh samples
         if (take && fresh) begin
            ha_ff[0] <= req_data.accel_x; ha_ff[1] <= req_data.accel_y;
            ha_ff[2] <= req_data.accel_z;
            hr_ff[0] <= req_data.rate_x;  hr_ff[1] <= req_data.rate_y;
            hr_ff[2] <= req_data.rate_z;
         end
         // post a new response when done, drop the response once taken
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.tilt_x       <= tilt[0];
         rsp_ff.tilt_y       <= tilt[1];
         rsp_ff.tilt_z       <= tilt[2];
         rsp_ff.motion_event <= motion;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   atilt_cell u_cell_x (.clock, .ctl, .root_step, .a_in(na[0]), .b_in(na[1]), .c_in(na[2]),
                        .tilt(tilt[0]));
   atilt_cell u_cell_y (.clock, .ctl, .root_step, .a_in(na[1]), .b_in(na[0]), .c_in(na[2]),
                        .tilt(tilt[1]));
   atilt_cell u_cell_z (.clock, .ctl, .root_step, .a_in(na[2]), .b_in(na[0]), .c_in(na[1]),
                        .tilt(tilt[2]));
endmodule

/* tb/tb_accel_tilt_angles_with_motion_flag.sv */
// Testbench for the accelerometer tilt block: predicted tilt angles and motion flag.
`timescale 1ns / 1ps
module tb_accel_tilt_angles_with_motion_flag;

   localparam int AtanTable [21] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4};

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   atilt_pkg::req_type req_data;
   atilt_pkg::rsp_type rsp_data;
   logic csr_valid, csr_ready;
   logic [atilt_pkg::CsrIndexWidth-1:0] csr_index;
   logic [31:0] csr_wdata;

   accel_tilt_angles_with_motion_flag dut (.*);

   // model state
   logic [14:0] thresh_q;
   logic [7:0] mask_q;
   logic signed [15:0] accel_q [3];
   logic signed [15:0] rate_q [3];
   atilt_pkg::rsp_type tilt_queue [$];
   int errors = 0;
   int mismatches = 0;
   int stall_left;
   bit rsp_idle_en;
   longint cycles = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // hold the run to a generous limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd1500000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] axis_tilt(longint a, longint b, longint c);
      longint x, y, z, nx, ny, r;
      if (b == 0 && c == 0) return a > 0 ? 16'sd23040 : (a < 0 ? -16'sd23040 : 16'sd0);
      if (a == 0) return 0;
      x = int_sqrt(longint'(b * b + c * c) << 32);
      y = a * 65536;
      z = 0;
      for (int i = 0; i < 21; i++) begin
         if (y > 0) begin
            nx = x + floor_shift(y, i);
            ny = y - floor_shift(x, i);
            z += AtanTable[i];
         end else begin
            nx = x - floor_shift(y, i);
            ny = y + floor_shift(x, i);
            z -= AtanTable[i];
         end
         x = nx;
         y = ny;
      end
      r = floor_shift(z + 128, 8);
      if (r > longint'(atilt_pkg::TiltLimit)) r = longint'(atilt_pkg::TiltLimit);
      if (r < -longint'(atilt_pkg::TiltLimit)) r = -longint'(atilt_pkg::TiltLimit);
      return r[15:0];
   endfunction

   function automatic atilt_pkg::rsp_type predict_tilt(atilt_pkg::req_type rq);
      atilt_pkg::rsp_type p;
      if ((rq.status_byte & mask_q) != 0) begin
         accel_q = '{rq.accel_x, rq.accel_y, rq.accel_z};
         rate_q = '{rq.rate_x, rq.rate_y, rq.rate_z};
      end
      p.tilt_x = axis_tilt(accel_q[0], accel_q[1], accel_q[2]);
      p.tilt_y = axis_tilt(accel_q[1], accel_q[0], accel_q[2]);
      p.tilt_z = axis_tilt(accel_q[2], accel_q[0], accel_q[1]);
      p.motion_event = 0;
      for (int k = 0; k < 3; k++)
         if (int'(rate_q[k]) > int'(thresh_q)) p.motion_event = 1;
      return p;
   endfunction

   // check each response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tilt_queue.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected response %h", rsp_data);
         end else begin
            atilt_pkg::rsp_type e;
            e = tilt_queue.pop_front();
            if (e !== rsp_data) begin
               errors++;
               if (mismatches++ < 10)
                  $display("mismatch: expected x=%0d y=%0d z=%0d m=%0b got x=%0d y=%0d z=%0d m=%0b",
                     e.tilt_x, e.tilt_y, e.tilt_z, e.motion_event, rsp_data.tilt_x,
                     rsp_data.tilt_y, rsp_data.tilt_z, rsp_data.motion_event);
            end
         end
      end
   end

   // receiver stalls in random bursts while rsp_idle_en is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if (rsp_idle_en && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1;
         stall_left <= int'($urandom_range(0, 3));
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send_sample(atilt_pkg::req_type rq, bit gaps);
      req_valid <= 1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tilt_queue.push_back(predict_tilt(rq));
      if (gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_wait();
      req_valid <= 0;
      while (tilt_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [atilt_pkg::CsrIndexWidth-1:0] idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == atilt_pkg::CSR_THRESHOLD) thresh_q = v[14:0];
      else mask_q = v[7:0];
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic atilt_pkg::req_type rand_item(bit fresh);
      atilt_pkg::req_type r;
      r.status_byte = fresh ? (8'($urandom) | 8'h01) : 8'($urandom);
      r.accel_x = rand_sample();
      r.accel_y = rand_sample();
      r.accel_z = rand_sample();
      r.rate_x = rand_sample();
      r.rate_y = rand_sample();
      r.rate_z = rand_sample();
      if ($urandom_range(0, 7) == 0) r.accel_y = 0;
      if ($urandom_range(0, 7) == 0) begin
         r.accel_y = 0;
         r.accel_z = 0;
      end
      return r;
   endfunction

   function automatic atilt_pkg::req_type make_item(logic [7:0] st, int ax, int ay, int az,
                                                    int rx, int ry, int rz);
      return '{st, 16'(ax), 16'(ay), 16'(az), 16'(rx), 16'(ry), 16'(rz)};
   endfunction

   // extremes, single-axis cases, masked status
   task automatic test_directed();
      send_sample(make_item(8'h00, 100, 100, 100, 9000, 0, 0), 0);
      send_sample(make_item(8'h01, 0, 0, 0, 0, 0, 0), 0);
      send_sample(make_item(8'h02, 1000, 0, 0, 8000, 8001, 0), 0);
      send_sample(make_item(8'h01, -1000, 0, 0, -32768, 0, 8001), 0);
      send_sample(make_item(8'h03, 0, 500, -500, 32767, 0, 0), 0);
      send_sample(make_item(8'hff, -32768, -32768, -32768, 0, 0, 0), 0);
      send_sample(make_item(8'h01, 32767, 32767, 32767, 0, 0, 0), 0);
      send_sample(make_item(8'h01, 32767, -32768, 0, 0, 0, 0), 0);
      send_sample(make_item(8'h01, 1, 32767, -32768, 0, 0, 0), 0);
      send_sample(make_item(8'h01, -1, 1, 0, 0, 0, 0), 0);
      send_sample(make_item(8'hfc, 5, 6, 7, 30000, 0, 0), 0);
      send_sample(make_item(8'h01, 0, 0, -7, 0, 0, 0), 0);
   endtask

   task automatic test_thresholds();
      drain_wait();
      write_reg(atilt_pkg::CSR_THRESHOLD, 32'hffff_0000);
      write_reg(atilt_pkg::CSR_MASK, 32'hffff_ff80);
      send_sample(make_item(8'h80, 10, 20, 30, 1, 0, 0), 0);
      send_sample(make_item(8'h7f, 10, 20, 30, 0, 0, 0), 0);
      send_sample(make_item(8'h80, 10, 20, 30, 0, -1, 0), 0);
      drain_wait();
      write_reg(atilt_pkg::CSR_THRESHOLD, 32'h7fff);
      write_reg(atilt_pkg::CSR_MASK, 0);
      send_sample(make_item(8'hff, 1, 2, 3, 32767, 0, 0), 0);
      drain_wait();
      write_reg(atilt_pkg::CSR_MASK, 32'hff);
      send_sample(make_item(8'h01, 1, 2, 3, 32767, 0, 0), 0);
   endtask

   task automatic test_random(int count, bit gaps);
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 149) begin
            drain_wait();
            write_reg(atilt_pkg::CSR_THRESHOLD,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40));
            write_reg(atilt_pkg::CSR_MASK, $urandom_range(0, 5) == 0 ? 0 : $urandom | 8'h01);
         end
         send_sample(rand_item($urandom_range(0, 9) != 0), gaps);
      end
   endtask

   initial begin
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_idle_en = 1;
      thresh_q = 15'd8000;
      mask_q = 8'h03;
      accel_q = '{0, 0, 0};
      rate_q = '{0, 0, 0};
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_thresholds();
      test_random(1400, 1);
      rsp_idle_en = 0;
      test_random(330, 0);
      drain_wait();
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

/* accel_tilt_angles_with_motion_flag.f */
rtl/atilt_pkg.sv
rtl/atilt_cell.sv
rtl/accel_tilt_angles_with_motion_flag.sv
tb/tb_accel_tilt_angles_with_motion_flag.sv
